// ----- hdl/cyvr_pkg.sv -----
// Shared types and constants of the CORDIC yaw vector rotation core.
package cyvr_pkg;

    localparam int CORDIC_MAX_STEPS = 31;
    localparam int CW = 34;

    localparam logic signed [CW-1:0] GAIN_INV_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE      = 34'sd1073741824;
    localparam logic [65:0]          ROUND_HALF   = 66'd536870912;
    localparam int                   Q_SHIFT      = 30;

    localparam logic signed [16:0] TURN_QUARTER = 17'sd16384;
    localparam logic signed [16:0] TURN_HALF    = 17'sd32768;

    localparam logic [29:0] ATAN_Q32 [0:CORDIC_MAX_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
    };

    typedef enum logic [1:0] {
        CARD_0   = 2'd0,
        CARD_90  = 2'd1,
        CARD_180 = 2'd2,
        CARD_270 = 2'd3
    } t_card;

    typedef struct packed {
        logic        card;
        t_card       quad;
        logic        neg;
    } t_ctl;

    typedef struct packed {
        logic               op;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_side;

endpackage

// ----- hdl/cyvr_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
interface cyvr_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        yaw;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;

    modport source (output valid, op, yaw, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, op, yaw, vec_x, vec_y, vec_z, output ready);
endinterface

interface cyvr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] sine;
    logic signed [31:0] cosine;

    modport source (output valid, rot_x, rot_y, rot_z, sine, cosine, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, sine, cosine, output ready);
endinterface

// ----- hdl/cyvr_sincos.sv -----
// Pipelined sine and cosine: angle fold, one CORDIC step per stage, clamp.
module cyvr_sincos #(
    parameter int STEPS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [15:0]         i_yaw,
    input  cyvr_pkg::t_side     i_side,
    output logic                o_valid,
    output logic signed [31:0]  o_sine,
    output logic signed [31:0]  o_cosine,
    output cyvr_pkg::t_side     o_side
);
    import cyvr_pkg::*;

    logic signed [16:0]   n_turn;
    logic                 n_neg;
    t_ctl                 n_ctl;

    logic                 r_f_vld;
    t_ctl                 r_f_ctl;
    logic signed [CW-1:0] r_f_z;
    t_side                r_f_side;

    logic                 r_vld  [0:STEPS-1];
    logic signed [CW-1:0] r_x    [0:STEPS-1];
    logic signed [CW-1:0] r_y    [0:STEPS-1];
    logic signed [CW-1:0] r_z    [0:STEPS-1];
    t_ctl                 r_ctl  [0:STEPS-1];
    t_side                r_side [0:STEPS-1];

    logic signed [CW-1:0] n_cx;
    logic signed [CW-1:0] n_cy;
    logic signed [31:0]   n_s;
    logic signed [31:0]   n_c;

    logic                 r_o_vld;
    logic signed [31:0]   r_s;
    logic signed [31:0]   r_c;
    t_side                r_o_side;

    function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
        logic signed [31:0] res;
        if (v > Q30_ONE) begin
            res = 32'(Q30_ONE);
        end else if (v < -Q30_ONE) begin
            res = 32'(-Q30_ONE);
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    always_comb begin
        n_turn = signed'({i_yaw[15], i_yaw});
        n_neg  = 1'b0;
        if (n_turn > TURN_QUARTER) begin
            n_turn = n_turn - TURN_HALF;
            n_neg  = 1'b1;
        end else if (n_turn < -TURN_QUARTER) begin
            n_turn = n_turn + TURN_HALF;
            n_neg  = 1'b1;
        end
        n_ctl.card = (i_yaw[13:0] == 14'd0);
        n_ctl.quad = t_card'(i_yaw[15:14]);
        n_ctl.neg  = n_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_ctl  <= n_ctl;
            r_f_z    <= CW'(signed'({n_turn, 16'd0}));
            r_f_side <= i_side;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                 w_vld;
        logic signed [CW-1:0] w_x;
        logic signed [CW-1:0] w_y;
        logic signed [CW-1:0] w_z;
        t_ctl                 w_ctl;
        t_side                w_side;
        logic signed [CW-1:0] w_atan;

        if (k == 0) begin : g_first
            assign w_vld  = r_f_vld;
            assign w_x    = GAIN_INV_Q30;
            assign w_y    = '0;
            assign w_z    = r_f_z;
            assign w_ctl  = r_f_ctl;
            assign w_side = r_f_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_x    = r_x[k-1];
            assign w_y    = r_y[k-1];
            assign w_z    = r_z[k-1];
            assign w_ctl  = r_ctl[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_atan = signed'({{(CW-30){1'b0}}, ATAN_Q32[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[CW-1]) begin
                    r_x[k] <= w_x - (w_y >>> k);
                    r_y[k] <= w_y + (w_x >>> k);
                    r_z[k] <= w_z - w_atan;
                end else begin
                    r_x[k] <= w_x + (w_y >>> k);
                    r_y[k] <= w_y - (w_x >>> k);
                    r_z[k] <= w_z + w_atan;
                end
                r_ctl[k]  <= w_ctl;
                r_side[k] <= w_side;
            end
        end
    end

    always_comb begin
        n_cx = r_ctl[STEPS-1].neg ? -r_x[STEPS-1] : r_x[STEPS-1];
        n_cy = r_ctl[STEPS-1].neg ? -r_y[STEPS-1] : r_y[STEPS-1];
        n_s  = clamp_q30(n_cy);
        n_c  = clamp_q30(n_cx);
        if (r_ctl[STEPS-1].card) begin
            case (r_ctl[STEPS-1].quad)
                CARD_0: begin
                    n_s = '0;
                    n_c = 32'(Q30_ONE);
                end
                CARD_90: begin
                    n_s = 32'(Q30_ONE);
                    n_c = '0;
                end
                CARD_180: begin
                    n_s = '0;
                    n_c = 32'(-Q30_ONE);
                end
                CARD_270: begin
                    n_s = 32'(-Q30_ONE);
                    n_c = '0;
                end
                default: begin
                    n_s = '0;
                    n_c = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s      <= n_s;
            r_c      <= n_c;
            r_o_side <= r_side[STEPS-1];
        end
    end

    assign o_valid  = r_o_vld;
    assign o_sine   = r_s;
    assign o_cosine = r_c;
    assign o_side   = r_o_side;

endmodule

// ----- hdl/cordic_yaw_vector_rotate_core.sv -----
// Top level of the CORDIC yaw vector rotation core.
//
//   Channel  Direction  Contents
//   i_in     in         op, yaw, vec_x, vec_y, vec_z
//   o_out    out        rot_x, rot_y, rot_z, sine, cosine
//
// One item enters per cycle while the output is not stalled; the pipeline holds
// one CORDIC step per stage plus fold, clamp, multiply, sum and rounding stages.
// Reset clears the valid bits of every stage; payload registers keep data.
// A stall at the output freezes the whole pipeline and drops i_in.ready until
// the waiting result transfer completes; nothing is lost or repeated.
module cordic_yaw_vector_rotate_core #(
    parameter int CORDIC_STEPS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cyvr_in_if.sink    i_in,
    cyvr_out_if.source o_out
);
    import cyvr_pkg::*;

    logic               w_en;
    t_side              w_side;
    logic               w_sc_vld;
    logic signed [31:0] w_s;
    logic signed [31:0] w_c;
    t_side              w_sc_side;

    logic               r_m_vld;
    logic signed [63:0] r_xc;
    logic signed [63:0] r_zs;
    logic signed [63:0] r_xs;
    logic signed [63:0] r_zc;
    logic               r_m_op;
    logic signed [31:0] r_m_y;
    logic signed [31:0] r_m_s;
    logic signed [31:0] r_m_c;

    logic               r_a_vld;
    logic signed [64:0] r_nx;
    logic signed [64:0] r_nz;
    logic signed [31:0] r_a_y;
    logic signed [31:0] r_a_s;
    logic signed [31:0] r_a_c;

    logic               r_o_vld;
    logic signed [31:0] r_rot_x;
    logic signed [31:0] r_rot_y;
    logic signed [31:0] r_rot_z;
    logic signed [31:0] r_sine;
    logic signed [31:0] r_cosine;

    function automatic logic signed [31:0] round_sat(input logic signed [64:0] n);
        logic signed [65:0] t;
        logic signed [35:0] q;
        logic signed [31:0] res;
        t = signed'({n[64], n} + ROUND_HALF - {65'd0, n[64]});
        q = 36'(t >>> Q_SHIFT);
        if (q > 36'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (q < -36'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = q[31:0];
        end
        return res;
    endfunction

    assign w_en       = !r_o_vld || o_out.ready;
    assign i_in.ready = w_en;

    assign w_side.op    = i_in.op;
    assign w_side.vec_x = i_in.vec_x;
    assign w_side.vec_y = i_in.vec_y;
    assign w_side.vec_z = i_in.vec_z;

    cyvr_sincos #(
        .STEPS (CORDIC_STEPS)
    ) u_sincos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in.valid),
        .i_yaw    (i_in.yaw),
        .i_side   (w_side),
        .o_valid  (w_sc_vld),
        .o_sine   (w_s),
        .o_cosine (w_c),
        .o_side   (w_sc_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= w_sc_vld;
            r_a_vld <= r_m_vld;
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xc   <= w_sc_side.vec_x * w_c;
            r_zs   <= w_sc_side.vec_z * w_s;
            r_xs   <= w_sc_side.vec_x * w_s;
            r_zc   <= w_sc_side.vec_z * w_c;
            r_m_op <= w_sc_side.op;
            r_m_y  <= w_sc_side.vec_y;
            r_m_s  <= w_s;
            r_m_c  <= w_c;

            if (r_m_op) begin
                r_nx <= 65'(r_xc) - 65'(r_zs);
                r_nz <= 65'(r_xs) + 65'(r_zc);
            end else begin
                r_nx <= 65'(r_xc) + 65'(r_zs);
                r_nz <= 65'(r_zc) - 65'(r_xs);
            end
            r_a_y <= r_m_y;
            r_a_s <= r_m_s;
            r_a_c <= r_m_c;

            r_rot_x  <= round_sat(r_nx);
            r_rot_z  <= round_sat(r_nz);
            r_rot_y  <= r_a_y;
            r_sine   <= r_a_s;
            r_cosine <= r_a_c;
        end
    end

    assign o_out.valid  = r_o_vld;
    assign o_out.rot_x  = r_rot_x;
    assign o_out.rot_y  = r_rot_y;
    assign o_out.rot_z  = r_rot_z;
    assign o_out.sine   = r_sine;
    assign o_out.cosine = r_cosine;

endmodule

// ----- hdl/cyvr_checker.sv -----
// Port-level assertions for the CORDIC yaw vector rotation core, with bind.
module cyvr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_rot_x,
    input logic signed [31:0] i_rot_z,
    input logic signed [31:0] i_sine,
    input logic signed [31:0] i_cosine
);

    // A result that waits for its transfer holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_rot_x)
            && $stable(i_rot_z) && $stable(i_sine) && $stable(i_cosine))
        else $error("result changed while stalled");

    // An empty output register never blocks the input side.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with output empty");

    a_sine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sine <= 32'sd1073741824) && (i_sine >= -32'sd1073741824))
        else $error("sine out of range");

    a_cosine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cosine <= 32'sd1073741824) && (i_cosine >= -32'sd1073741824))
        else $error("cosine out of range");

endmodule

bind cordic_yaw_vector_rotate_core cyvr_checker u_cyvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rot_x     (o_out.rot_x),
    .i_rot_z     (o_out.rot_z),
    .i_sine      (o_out.sine),
    .i_cosine    (o_out.cosine)
);

// ----- tb/sv/cordic_yaw_vector_rotate_core_test.sv -----
// Self-checking testbench for the CORDIC yaw vector rotation core.
package cyvr_test_pkg;

    localparam logic OP_LOCAL_TO_WORLD = 1'b0;
    localparam logic OP_WORLD_TO_LOCAL = 1'b1;

    localparam logic [15:0] YAW_0   = 16'd0;
    localparam logic [15:0] YAW_90  = 16'd16384;
    localparam logic [15:0] YAW_180 = 16'd32768;
    localparam logic [15:0] YAW_270 = 16'd49152;

    localparam longint UNIT_Q30   = 64'sd1073741824;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam int     ROT_STEPS  = 31;

    typedef struct {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } t_rotation;

    class rotation_scoreboard;
        t_rotation pending_rotations[$];
        int        mismatches;
        longint    atan_turn_q32[ROT_STEPS];

        function new();
            mismatches = 0;
            atan_turn_q32 = '{
                536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                163, 81, 41, 20, 10, 5, 3, 1, 1
            };
        endfunction

        function longint clamp_unit(longint v);
            if (v > UNIT_Q30) begin
                return UNIT_Q30;
            end
            if (v < -UNIT_Q30) begin
                return -UNIT_Q30;
            end
            return v;
        endfunction

        function void yaw_sincos(logic [15:0] yaw, output longint s, output longint c);
            longint turn;
            longint x;
            longint y;
            longint z;
            longint px;
            longint flip;
            int     i;
            case (yaw)
                YAW_0: begin
                    s = 0;
                    c = UNIT_Q30;
                    return;
                end
                YAW_90: begin
                    s = UNIT_Q30;
                    c = 0;
                    return;
                end
                YAW_180: begin
                    s = 0;
                    c = -UNIT_Q30;
                    return;
                end
                YAW_270: begin
                    s = -UNIT_Q30;
                    c = 0;
                    return;
                end
                default: begin
                end
            endcase
            turn = yaw[15] ? longint'(yaw) - 65536 : longint'(yaw);
            flip = 1;
            if (turn > 16384) begin
                turn = turn - 32768;
                flip = -1;
            end else if (turn < -16384) begin
                turn = turn + 32768;
                flip = -1;
            end
            x = GAIN_Q30;
            y = 0;
            z = turn * 65536;
            for (i = 0; i < ROT_STEPS; i++) begin
                px = x;
                if (z >= 0) begin
                    x = x - (y >>> i);
                    y = y + (px >>> i);
                    z = z - atan_turn_q32[i];
                end else begin
                    x = x + (y >>> i);
                    y = y - (px >>> i);
                    z = z + atan_turn_q32[i];
                end
            end
            c = clamp_unit(x * flip);
            s = clamp_unit(y * flip);
        endfunction

        function logic signed [31:0] q30_round_sat(longint n);
            longint mag;
            longint q;
            if (n == 0) begin
                return 32'sd0;
            end
            mag = (n < 0) ? -n : n;
            q = mag >>> 30;
            if ((mag & 64'h3FFFFFFF) >= 64'h20000000) begin
                q = q + 1;
            end
            if (n < 0) begin
                q = -q;
            end
            if (q > 64'sd2147483647) begin
                q = 64'sd2147483647;
            end
            if (q < -64'sd2147483648) begin
                q = -64'sd2147483648;
            end
            return q[31:0];
        endfunction

        function void note_transfer(logic op, logic [15:0] yaw, logic signed [31:0] vx,
                                    logic signed [31:0] vy, logic signed [31:0] vz);
            t_rotation want;
            longint    s;
            longint    c;
            longint    x;
            longint    z;
            longint    nx;
            longint    nz;
            yaw_sincos(yaw, s, c);
            x = vx;
            z = vz;
            if (op == OP_LOCAL_TO_WORLD) begin
                nx = x * c + z * s;
                nz = -x * s + z * c;
            end else begin
                nx = x * c - z * s;
                nz = x * s + z * c;
            end
            want.rot_x  = q30_round_sat(nx);
            want.rot_y  = vy;
            want.rot_z  = q30_round_sat(nz);
            want.sine   = s[31:0];
            want.cosine = c[31:0];
            pending_rotations.push_back(want);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_transfer(t_rotation got);
            t_rotation want;
            if (pending_rotations.size() == 0) begin
                $error("result transfer with no rotation pending");
                mismatches++;
                return;
            end
            want = pending_rotations.pop_front();
            compare_field("rot_x", want.rot_x, got.rot_x);
            compare_field("rot_y", want.rot_y, got.rot_y);
            compare_field("rot_z", want.rot_z, got.rot_z);
            compare_field("sine", want.sine, got.sine);
            compare_field("cosine", want.cosine, got.cosine);
        endfunction
    endclass

endpackage

module cordic_yaw_vector_rotate_core_test;
    import cyvr_test_pkg::*;

    localparam logic signed [31:0] VMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VMIN = 32'sh80000000;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;
    int   send_gap_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    rotation_scoreboard rotation_board;

    cyvr_in_if  in_ch ();
    cyvr_out_if out_ch ();

    cordic_yaw_vector_rotate_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        rotation_board = new();
        quiet_cycles = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
    end

    always @(posedge i_clk) begin
        t_rotation got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                rotation_board.note_transfer(in_ch.op, in_ch.yaw, in_ch.vec_x, in_ch.vec_y,
                                             in_ch.vec_z);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.rot_x  = out_ch.rot_x;
                got.rot_y  = out_ch.rot_y;
                got.rot_z  = out_ch.rot_z;
                got.sine   = out_ch.sine;
                got.cosine = out_ch.cosine;
                rotation_board.check_transfer(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end
        $display("cordic_yaw_vector_rotate_core_test: done, errors");
        $finish;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_rotation(logic op, logic [15:0] yaw, logic signed [31:0] vx,
                                 logic signed [31:0] vy, logic signed [31:0] vz);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.yaw   <= yaw;
        in_ch.vec_x <= vx;
        in_ch.vec_y <= vy;
        in_ch.vec_z <= vz;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
    endtask

    task automatic wait_for_rotations();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rotation_board.pending_rotations.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] random_component();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: return VMAX;
                    1: return VMIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $urandom;
            3, 4, 5: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $signed($urandom) >>> 8;
        endcase
    endfunction

    task automatic send_random_rotations(int count);
        logic [15:0] yaw;
        logic [15:0] base;
        repeat (count) begin
            if ($urandom_range(0, 9) < 2) begin
                case ($urandom_range(0, 3))
                    0: base = YAW_0;
                    1: base = YAW_90;
                    2: base = YAW_180;
                    default: base = YAW_270;
                endcase
                yaw = base + 16'($urandom_range(0, 4)) - 16'd2;
            end else begin
                yaw = 16'($urandom);
            end
            send_rotation(1'($urandom), yaw, random_component(), random_component(),
                          random_component());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_LOCAL_TO_WORLD;
        in_ch.yaw   <= 16'd0;
        in_ch.vec_x <= 32'sd0;
        in_ch.vec_y <= 32'sd0;
        in_ch.vec_z <= 32'sd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 20;
        recv_stall_pct = 20;
        send_rotation(OP_LOCAL_TO_WORLD, YAW_0, 32'sd1000, -32'sd5, -32'sd2000);
        send_rotation(OP_WORLD_TO_LOCAL, YAW_0, VMAX, VMIN, VMIN);
        send_rotation(OP_LOCAL_TO_WORLD, YAW_90, VMAX, 32'sd7, VMIN);
        send_rotation(OP_WORLD_TO_LOCAL, YAW_90, VMIN, VMAX, VMAX);
        send_rotation(OP_LOCAL_TO_WORLD, YAW_180, VMIN, 32'sd0, VMAX);
        send_rotation(OP_WORLD_TO_LOCAL, YAW_180, 32'sd123456, 32'sd1, -32'sd654321);
        send_rotation(OP_LOCAL_TO_WORLD, YAW_270, VMAX, -32'sd1, VMAX);
        send_rotation(OP_WORLD_TO_LOCAL, YAW_270, VMIN, 32'sd42, VMIN);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd8192, VMAX, 32'sd0, VMAX);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd8192, VMIN, 32'sd0, VMAX);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd24576, VMIN, VMAX, VMIN);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd40960, VMAX, VMIN, VMIN);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd1, VMAX, 32'sd3, VMAX);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd65535, VMIN, -32'sd3, VMAX);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd16383, 32'sd99999, 32'sd11, -32'sd77777);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd16385, -32'sd99999, 32'sd12, 32'sd77777);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd32767, VMAX, 32'sd13, 32'sd1);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd32769, VMIN, 32'sd14, -32'sd1);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd49151, 32'sd1, 32'sd15, VMAX);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd49153, -32'sd1, 32'sd16, VMIN);
        send_rotation(OP_LOCAL_TO_WORLD, 16'd12345, 32'sd0, 32'sd0, 32'sd0);
        send_rotation(OP_WORLD_TO_LOCAL, 16'd57344, -32'sd1, 32'sd1, 32'sd1);
        wait_for_rotations();

        send_gap_pct = 30;
        recv_stall_pct = 30;
        send_random_rotations(400);
        wait_for_rotations();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_random_rotations(300);

        send_gap_pct = 10;
        recv_stall_pct = 50;
        send_random_rotations(350);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_random_rotations(200);

        wait_for_rotations();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rotation_board.mismatches == 0 && rotation_board.pending_rotations.size() == 0)
        begin
            $display("cordic_yaw_vector_rotate_core_test: done, clean");
        end else begin
            $display("cordic_yaw_vector_rotate_core_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cyvr_pkg.sv
hdl/cyvr_if.sv
hdl/cyvr_sincos.sv
hdl/cordic_yaw_vector_rotate_core.sv
hdl/cyvr_checker.sv
tb/sv/cordic_yaw_vector_rotate_core_test.sv
